// ----- hw/rtl/fmls_pkg.sv -----
// shared types, constants and rom contents of the fm operator log-sine output unit
package fmls_pkg;

  localparam int unsigned PhaseWidth  = 10;
  localparam int unsigned PmWidth     = 15;
  localparam int unsigned LevelWidth  = 7;
  localparam int unsigned SampleWidth = 14;
  localparam int unsigned QuarterWidth = 8;
  localparam int unsigned AttenWidth  = 12;
  localparam int unsigned ExpWidth    = 11;
  localparam int unsigned MagWidth    = 13;
  localparam int unsigned RomDepth    = 256;

  localparam logic [LevelWidth-1:0] TotalLevelReset = 7'd127;

  // log2(e), turns a natural log into a base-2 log
  localparam real Log2E = 1.4426950408889634074;

  typedef logic [AttenWidth-1:0] log_sine_rom_t [RomDepth];
  typedef logic [ExpWidth-1:0]   exp_rom_t      [RomDepth];

  // stage 1 result: sign and quarter-wave index
  typedef struct packed {
    logic                    negative;
    logic [QuarterWidth-1:0] quarter;
  } phase_res_t;

  // stage 2 result: sign and total attenuation in 4.8 fixed point
  typedef struct packed {
    logic                  negative;
    logic [AttenWidth-1:0] atten;
  } atten_res_t;

  // quarter sine attenuation: round(256 * -log2(sin((2i+1) * pi / 1024)))
  function automatic log_sine_rom_t log_sine_contents();
    log_sine_rom_t rom;
    real           x;
    real           v;
    for (int i = 0; i < RomDepth; i++) begin
      x = (2.0 * i + 1.0) * 3.14159265358979323846 / 1024.0;
      v = -$ln($sin(x)) * Log2E * 256.0;
      rom[i] = AttenWidth'($rtoi(v + 0.5));
    end
    return rom;
  endfunction

  // inverse power of two: round(2048 * 2^(-(i+1)/256))
  function automatic exp_rom_t exp_contents();
    exp_rom_t rom;
    real      v;
    for (int i = 0; i < RomDepth; i++) begin
      v = 2048.0 * $pow(2.0, -(i + 1.0) / 256.0);
      rom[i] = ExpWidth'($rtoi(v + 0.5));
    end
    return rom;
  endfunction

endpackage

// ----- hw/rtl/fm_operator_log_sine_output_unit.sv -----
// top level of the fm operator log-sine output unit
//
// Input channel (in_valid_i / in_ready_o) carries one request per item: a
// 10-bit phase and a signed 15-bit phase modulation. Output channel
// (out_valid_o / out_ready_i) returns one signed 14-bit sample per request,
// in order. total_level_i is written when total_level_we_i is high and must
// only change while no request is in flight.
// Pipeline: three register stages (phase offset, log-sine lookup plus level,
// exponent lookup plus shift and sign); an accepted request passes through
// each of them in order before its sample shows on out_valid_o.
// Throughput: one request per cycle while out_ready_i stays high; each stage
// holds one item and passes it on in the same cycle the next stage frees up.
// Reset clears all stage valid bits and sets the total level to 127.
// When the receiver stalls, the stages fill up one by one and in_ready_o
// drops once all three are full; nothing is dropped or repeated.
module fm_operator_log_sine_output_unit (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    in_valid_i,
  output logic                                    in_ready_o,
  input  logic [fmls_pkg::PhaseWidth-1:0]         phase_i,
  input  logic signed [fmls_pkg::PmWidth-1:0]     phase_modulation_i,
  output logic                                    out_valid_o,
  input  logic                                    out_ready_i,
  output logic signed [fmls_pkg::SampleWidth-1:0] sample_o,
  input  logic                                    total_level_we_i,
  input  logic [fmls_pkg::LevelWidth-1:0]         total_level_i
);

  logic [fmls_pkg::LevelWidth-1:0] total_level_q;
  logic                            s1_valid, s1_ready;
  logic                            s2_valid, s2_ready;
  fmls_pkg::phase_res_t            s1_res;
  fmls_pkg::atten_res_t            s2_res;

  // total level register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_level_q <= fmls_pkg::TotalLevelReset;
    end else if (total_level_we_i) begin
      total_level_q <= total_level_i;
    end
  end

  // phase offset and quarter-wave index
  fmls_phase_stage u_phase_stage (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .valid_i            (in_valid_i),
    .ready_o            (in_ready_o),
    .phase_i            (phase_i),
    .phase_modulation_i (phase_modulation_i),
    .valid_o            (s1_valid),
    .ready_i            (s1_ready),
    .res_o              (s1_res)
  );

  // log-sine lookup and level add
  fmls_log_stage u_log_stage (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .valid_i       (s1_valid),
    .ready_o       (s1_ready),
    .res_i         (s1_res),
    .total_level_i (total_level_q),
    .valid_o       (s2_valid),
    .ready_i       (s2_ready),
    .res_o         (s2_res)
  );

  // exponent lookup, shift and sign
  fmls_exp_stage u_exp_stage (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (s2_valid),
    .ready_o  (s2_ready),
    .res_i    (s2_res),
    .valid_o  (out_valid_o),
    .ready_i  (out_ready_i),
    .sample_o (sample_o)
  );

endmodule

// ----- hw/rtl/fmls_phase_stage.sv -----
// stage 1: phase modulation, sign and quarter-wave index
module fmls_phase_stage (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    valid_i,
  output logic                                    ready_o,
  input  logic [fmls_pkg::PhaseWidth-1:0]         phase_i,
  input  logic signed [fmls_pkg::PmWidth-1:0]     phase_modulation_i,
  output logic                                    valid_o,
  input  logic                                    ready_i,
  output fmls_pkg::phase_res_t                    res_o
);

  logic                                valid_q;
  fmls_pkg::phase_res_t                res_d, res_q;
  logic signed [fmls_pkg::PmWidth:0]   pm_biased;
  logic [fmls_pkg::PhaseWidth-1:0]     pm_div;
  logic [fmls_pkg::PhaseWidth-1:0]     mod_phase;

  // divide by 32 toward zero: bias negatives by 31, then shift
  always_comb begin
    pm_biased = {phase_modulation_i[fmls_pkg::PmWidth-1], phase_modulation_i}
              + ((phase_modulation_i[fmls_pkg::PmWidth-1])
                 ? (fmls_pkg::PmWidth+1)'(31) : (fmls_pkg::PmWidth+1)'(0));
    pm_div    = pm_biased[fmls_pkg::PmWidth-1:5];
    mod_phase = phase_i + pm_div;
    res_d.negative = mod_phase[9];
    res_d.quarter  = mod_phase[7:0] ^ {fmls_pkg::QuarterWidth{mod_phase[8]}};
  end

  assign ready_o = !valid_q || ready_i;

  // valid bit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      res_q <= res_d;
    end
  end

  assign valid_o = valid_q;
  assign res_o   = res_q;

endmodule

// ----- hw/rtl/fmls_log_stage.sv -----
// stage 2: log-sine rom lookup and total level add
module fmls_log_stage (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               valid_i,
  output logic                               ready_o,
  input  fmls_pkg::phase_res_t               res_i,
  input  logic [fmls_pkg::LevelWidth-1:0]    total_level_i,
  output logic                               valid_o,
  input  logic                               ready_i,
  output fmls_pkg::atten_res_t               res_o
);

  localparam fmls_pkg::log_sine_rom_t LogSineRom = fmls_pkg::log_sine_contents();

  logic                  valid_q;
  fmls_pkg::atten_res_t  res_d, res_q;

  // attenuation = log-sine + total level * 4
  always_comb begin
    res_d.negative = res_i.negative;
    res_d.atten    = LogSineRom[res_i.quarter]
                   + {{(fmls_pkg::AttenWidth-fmls_pkg::LevelWidth-2){1'b0}},
                      total_level_i, 2'b00};
  end

  assign ready_o = !valid_q || ready_i;

  // valid bit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      res_q <= res_d;
    end
  end

  assign valid_o = valid_q;
  assign res_o   = res_q;

endmodule

// ----- hw/rtl/fmls_exp_stage.sv -----
// stage 3: exponent rom lookup, shift and sign, output register
module fmls_exp_stage (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  valid_i,
  output logic                                  ready_o,
  input  fmls_pkg::atten_res_t                  res_i,
  output logic                                  valid_o,
  input  logic                                  ready_i,
  output logic signed [fmls_pkg::SampleWidth-1:0] sample_o
);

  localparam fmls_pkg::exp_rom_t ExpRom = fmls_pkg::exp_contents();

  logic                                    valid_q;
  logic [fmls_pkg::MagWidth-1:0]           mag_base;
  logic [fmls_pkg::MagWidth-1:0]           mag;
  logic [fmls_pkg::AttenWidth-9:0]         whole;
  logic [fmls_pkg::SampleWidth-1:0]        sample_d, sample_q;

  // linear magnitude from the fractional part, scaled by the integer part
  always_comb begin
    whole    = res_i.atten[fmls_pkg::AttenWidth-1:8];
    mag_base = {ExpRom[res_i.atten[7:0]], 2'b00};
    mag      = mag_base >> whole;
    sample_d = res_i.negative ? (fmls_pkg::SampleWidth)'(0) - {1'b0, mag}
                              : {1'b0, mag};
  end

  assign ready_o = !valid_q || ready_i;

  // valid bit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      sample_q <= sample_d;
    end
  end

  assign valid_o  = valid_q;
  assign sample_o = sample_q;

endmodule
